// File: rtl/core/gtp_pkg.sv
// Shared types, character codes and decode functions for the GUID text parser.
package gtp_pkg;

    localparam logic [5:0] TEXT_LEN = 6'd36;

    localparam logic [5:0] DASH_POS_A = 6'd8;
    localparam logic [5:0] DASH_POS_B = 6'd13;
    localparam logic [5:0] DASH_POS_C = 6'd18;
    localparam logic [5:0] DASH_POS_D = 6'd23;

    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    // One command from the decoder to the byte assembler.
    typedef struct packed {
        logic       wr;
        logic [3:0] slot;
        logic [7:0] data;
        logic       last;
        logic       ok;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } nibble_t;

    // Maps the index of a digit pair to its byte place in the binary GUID.
    function automatic logic [3:0] byte_slot(input logic [3:0] pair);
        logic [3:0] slot;
        case (pair)
            4'd0:    slot = 4'd3;
            4'd1:    slot = 4'd2;
            4'd2:    slot = 4'd1;
            4'd3:    slot = 4'd0;
            4'd4:    slot = 4'd5;
            4'd5:    slot = 4'd4;
            4'd6:    slot = 4'd7;
            4'd7:    slot = 4'd6;
            default: slot = pair;
        endcase
        return slot;
    endfunction

    function automatic nibble_t hex_value(input logic [7:0] c);
        nibble_t    n;
        logic [7:0] diff;
        diff = 8'd0;
        n.valid = 1'b1;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            diff = c - CH_ZERO;
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
        begin
            diff = c - CH_LOWER_A + HEX_TEN;
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
        begin
            diff = c - CH_UPPER_A + HEX_TEN;
        end
        else
        begin
            n.valid = 1'b0;
        end
        n.value = diff[3:0];
        return n;
    endfunction

endpackage

// File: rtl/core/gtp_front.sv
// Character decoder: tracks the text position, checks each character and issues byte commands.
module gtp_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    ch,
    input  logic          last,
    output gtp_pkg::cmd_t cmd
);

    logic [5:0] position_reg, position_next;
    logic       bad_reg, bad_next;
    logic [3:0] high_nibble_reg, high_nibble_next;

    gtp_pkg::nibble_t nib;
    logic             in_text;
    logic             dash_pos;
    logic [2:0]       dashes;
    logic [5:0]       digit_idx;
    logic             bad_now;
    logic [3:0]       value;

    always_comb
    begin
        nib      = gtp_pkg::hex_value(ch);
        in_text  = position_reg < gtp_pkg::TEXT_LEN;
        dash_pos = position_reg inside {gtp_pkg::DASH_POS_A, gtp_pkg::DASH_POS_B,
                                        gtp_pkg::DASH_POS_C, gtp_pkg::DASH_POS_D};
        dashes   = 3'(position_reg > gtp_pkg::DASH_POS_A)
                 + 3'(position_reg > gtp_pkg::DASH_POS_B)
                 + 3'(position_reg > gtp_pkg::DASH_POS_C)
                 + 3'(position_reg > gtp_pkg::DASH_POS_D);
        // Index of the hex digit within the text, dashes skipped.
        digit_idx = position_reg - {3'd0, dashes};
        value     = nib.valid ? nib.value : 4'd0;

        bad_now = 1'b0;
        if (in_text)
        begin
            bad_now = dash_pos ? (ch != gtp_pkg::CH_DASH) : !nib.valid;
        end

        cmd.wr   = in_text && !dash_pos && digit_idx[0];
        cmd.slot = gtp_pkg::byte_slot(digit_idx[4:1]);
        cmd.data = {high_nibble_reg, value};
        cmd.last = last;

        bad_next         = bad_reg | bad_now;
        position_next    = in_text ? position_reg + 6'd1 : position_reg;
        high_nibble_next = (in_text && !dash_pos && !digit_idx[0]) ? value : high_nibble_reg;

        cmd.ok = !bad_next && (position_next >= gtp_pkg::TEXT_LEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            bad_reg         <= 1'b0;
            high_nibble_reg <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                position_reg    <= '0;
                bad_reg         <= 1'b0;
                high_nibble_reg <= '0;
            end
            else
            begin
                position_reg    <= position_next;
                bad_reg         <= bad_next;
                high_nibble_reg <= high_nibble_next;
            end
        end
    end

endmodule

// File: rtl/core/gtp_queue.sv
// Small command queue between the decoder and the byte assembler.
module gtp_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gtp_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output gtp_pkg::cmd_t pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gtp_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/gtp_back.sv
// Byte assembler: stores decoded bytes and drives the registered result word.
module gtp_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    input  gtp_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [127:0]  out_data,
    output logic          out_ok
);

    logic [7:0]   bytes_reg [16];
    logic [7:0]   merged [16];
    logic [127:0] packed_bytes;
    logic         valid_reg, valid_next;
    logic [127:0] data_reg;
    logic         ok_reg;
    logic         load;

    assign cmd_pop   = !cmd_empty && (!valid_reg || out_ready);
    assign load      = cmd_pop && cmd.last;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_ok    = ok_reg;

    // The byte written by the closing character is already part of the result.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            merged[i] = (cmd.wr && cmd.slot == 4'(i)) ? cmd.data : bytes_reg[i];
            packed_bytes[i*8 +: 8] = merged[i];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.wr)
        begin
            bytes_reg[cmd.slot] <= cmd.data;
        end
        if (load)
        begin
            data_reg <= cmd.ok ? packed_bytes : '0;
            ok_reg   <= cmd.ok;
        end
    end

endmodule

// File: rtl/core/guid_text_parser.sv
// GUID text parser: one character per word in, one 16-byte binary GUID per string out.
// The block takes one character per clock while the command queue has room. m_tvalid rises
// once a string's closing character (tlast) has left the queue for the output register, when
// no earlier result is still waiting. The rate is set by the decoder, which checks one
// character and forms at most one byte per clock. A command queue of QUEUE_DEPTH entries and
// a registered output stage decouple the two sides: while a result waits to be taken, the
// input side keeps accepting words until the queue holds QUEUE_DEPTH of them. A string gives
// ok (tuser) high only if its first 36 characters form the 8-4-4-4-12 text form; otherwise
// the 128 data bits are zero. Characters beyond the 36th are ignored until tlast.
module guid_text_parser
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] ch
    input  logic         s_tlast,   // last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] guid_low, [127:64] guid_high
    output logic         m_tuser    // [0] ok
);

    gtp_pkg::cmd_t front_cmd;
    gtp_pkg::cmd_t queue_cmd;
    logic          take;
    logic          queue_full;
    logic          queue_empty;
    logic          queue_pop;

    assign s_tready = !queue_full;
    assign take     = s_tvalid && s_tready;

    gtp_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .ch    (s_tdata),
        .last  (s_tlast),
        .cmd   (front_cmd)
    );

    gtp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (take),
        .push_cmd (front_cmd),
        .full     (queue_full),
        .pop      (queue_pop),
        .empty    (queue_empty),
        .pop_cmd  (queue_cmd)
    );

    gtp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (queue_empty),
        .cmd       (queue_cmd),
        .cmd_pop   (queue_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_ok    (m_tuser)
    );

endmodule

// File: rtl/core/gtp_checker.sv
// Port-level checks for the GUID text parser, bound to the top level.
module gtp_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);

    logic [7:0] pending_reg;
    logic       in_end;
    logic       out_take;

    assign in_end   = s_tvalid && s_tready && s_tlast;
    assign out_take = m_tvalid && m_tready;

    // Strings whose closing word was accepted but whose result has not been taken yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 8'(in_end) - 8'(out_take);
        end
    end

    a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("failed parse delivered nonzero data");

    a_no_extra : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pending_reg != '0))
        else $error("result word shown without a closing input word");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind guid_text_parser gtp_checker u_checker (.*);
